[design/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, codes and constants of the chained hash table core.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int BUCKETS_DEF        = 16;
    localparam int SLOTS_DEF          = 4;
    localparam int RESET_BUCKET_COUNT = 10;
    localparam int KEY_W              = 31;
    localparam int VAL_W              = 64;
    localparam int BC_W               = 5;

    typedef enum logic [2:0] {
        REQ_INSERT    = 3'd0,
        REQ_FIND_KEY  = 3'd1,
        REQ_FIND_VAL  = 3'd2,
        REQ_REMOVE_KEY = 3'd3,
        REQ_REMOVE_VAL = 3'd4,
        REQ_STATS     = 3'd5
    } req_e_t;

    typedef enum logic [3:0] {
        ST_INSERTED  = 4'd0,
        ST_DUPLICATE = 4'd1,
        ST_FULL      = 4'd2,
        ST_FOUND     = 4'd3,
        ST_NOT_FOUND = 4'd4,
        ST_REMOVED   = 4'd5,
        ST_MATCH     = 4'd6,
        ST_VAL_DONE  = 4'd7,
        ST_STATS     = 4'd8
    } status_e_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_BUCKET,
        S_RD,
        S_CHK,
        S_PUSH,
        S_BEND,
        S_DONE
    } state_e_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_bucket;
        logic rd;
        logic chk;
        logic push;
        logic bend;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_invalid;
        logic in_stats;
        logic in_keyed;
        logic div_done;
        logic fill_zero;
        logic hit_end;
        logic push_need;
        logic last_slot;
        logic more_buckets;
        logic out_free;
    } sts_t;

    typedef struct packed {
        status_e_t          status;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic               last;
        logic [6:0]         total;
        logic [4:0]         nonempty;
        logic [31:0]        coll;
    } res_t;

    function automatic res_t make_res(status_e_t st, logic [KEY_W-1:0] k,
                                      logic [VAL_W-1:0] v, logic last);
        res_t r;
        r.status   = st;
        r.key      = k;
        r.value    = v;
        r.last     = last;
        r.total    = '0;
        r.nonempty = '0;
        r.coll     = '0;
        return r;
    endfunction

endpackage

[design/cht_ctrl.sv]
// ----------------------------------------------------------------------------
// cht_ctrl
// Request sequencer: steps the modulo, bucket scan and result hand-off.
// ----------------------------------------------------------------------------
module cht_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cht_pkg::sts_t    sts,
    output cht_pkg::cmd_t    cmd
);

    cht_pkg::state_e_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cht_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cht_pkg::S_IDLE: begin
                if (s_valid) begin
                    priority if (sts.in_invalid) state_next = cht_pkg::S_IDLE;
                    else if (sts.in_stats)       state_next = cht_pkg::S_DONE;
                    else if (sts.in_keyed)       state_next = cht_pkg::S_DIV;
                    else                         state_next = cht_pkg::S_BUCKET;
                end
            end
            cht_pkg::S_DIV: begin
                if (sts.div_done) state_next = cht_pkg::S_BUCKET;
            end
            cht_pkg::S_BUCKET: begin
                state_next = sts.fill_zero ? cht_pkg::S_BEND : cht_pkg::S_RD;
            end
            cht_pkg::S_RD: begin
                state_next = cht_pkg::S_CHK;
            end
            cht_pkg::S_CHK: begin
                priority if (sts.hit_end)  state_next = cht_pkg::S_DONE;
                else if (sts.push_need)    state_next = cht_pkg::S_PUSH;
                else if (sts.last_slot)    state_next = cht_pkg::S_BEND;
                else                       state_next = cht_pkg::S_RD;
            end
            cht_pkg::S_PUSH: begin
                if (sts.out_free) begin
                    state_next = sts.last_slot ? cht_pkg::S_BEND : cht_pkg::S_RD;
                end
            end
            cht_pkg::S_BEND: begin
                state_next = sts.more_buckets ? cht_pkg::S_BUCKET : cht_pkg::S_DONE;
            end
            cht_pkg::S_DONE: begin
                if (sts.out_free) state_next = cht_pkg::S_IDLE;
            end
            default: state_next = cht_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            cht_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            cht_pkg::S_DIV:    cmd.div_step    = 1'b1;
            cht_pkg::S_BUCKET: cmd.load_bucket = 1'b1;
            cht_pkg::S_RD:     cmd.rd          = 1'b1;
            cht_pkg::S_CHK:    cmd.chk         = 1'b1;
            cht_pkg::S_PUSH:   cmd.push        = sts.out_free;
            cht_pkg::S_BEND:   cmd.bend        = 1'b1;
            cht_pkg::S_DONE:   cmd.emit        = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

[design/cht_datapath.sv]
// ----------------------------------------------------------------------------
// cht_datapath
// Slot memory, bucket fill counts, modulo unit, counters and result register.
// ----------------------------------------------------------------------------
module cht_datapath #(
    parameter int BUCKETS          = cht_pkg::BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = cht_pkg::SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cht_pkg::cmd_t               cmd,
    output cht_pkg::sts_t               sts,
    input  logic [2:0]                  s_req_type,
    input  logic [cht_pkg::KEY_W-1:0]   s_key,
    input  logic [cht_pkg::VAL_W-1:0]   s_data_value,
    input  logic                        cfg_we,
    input  logic [cht_pkg::BC_W-1:0]    cfg_wdata,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [3:0]                  m_status,
    output logic [cht_pkg::KEY_W-1:0]   m_out_key,
    output logic [cht_pkg::VAL_W-1:0]   m_out_value,
    output logic                        m_is_last,
    output logic [6:0]                  m_total_entries,
    output logic [4:0]                  m_nonempty_buckets,
    output logic [31:0]                 m_collision_total
);

    localparam int KW    = cht_pkg::KEY_W;
    localparam int VW    = cht_pkg::VAL_W;
    localparam int EW    = KW + VW;
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int AW    = BW + SW;
    localparam int DEPTH = 2 ** AW;
    localparam int TW    = $clog2(BUCKETS * SLOTS_PER_BUCKET + 1);
    localparam int NEW   = $clog2(BUCKETS + 1);
    localparam int NW    = (BW + 1 > cht_pkg::BC_W) ? BW + 1 : cht_pkg::BC_W;
    localparam int RBC   = (cht_pkg::RESET_BUCKET_COUNT > BUCKETS) ?
                           BUCKETS : cht_pkg::RESET_BUCKET_COUNT;

    logic [EW-1:0]              mem [DEPTH];
    logic [EW-1:0]              rd_data_reg;

    cht_pkg::req_e_t            req_reg;
    logic [KW-1:0]              key_reg;
    logic [VW-1:0]              val_reg;
    logic [KW-1:0]              div_sh_reg;
    logic [cht_pkg::BC_W-1:0]   rem_reg;
    logic [4:0]                 cnt_reg;
    logic [BW-1:0]              b_reg;
    logic [FW-1:0]              fill_reg;
    logic [FW-1:0]              r_reg;
    logic [FW-1:0]              w_reg;
    logic                       dropped_reg;
    logic                       pend_valid_reg;
    logic [KW-1:0]              pend_key_reg;
    logic [31:0]                coll_reg;
    logic [TW-1:0]              total_reg;
    logic [NEW-1:0]             nonempty_reg;
    logic [cht_pkg::BC_W-1:0]   bc_reg;
    logic [FW-1:0]              fill_arr_reg [BUCKETS];
    cht_pkg::res_t              res_reg;
    cht_pkg::res_t              out_reg;
    logic                       m_valid_reg;

    logic [KW-1:0]              rd_key;
    logic [VW-1:0]              rd_val;
    logic                       key_hit;
    logic                       val_hit;
    logic [cht_pkg::BC_W:0]     trial;
    logic [cht_pkg::BC_W-1:0]   rem_next;
    logic                       is_remove;
    logic                       keep;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [EW-1:0]              wdata;
    logic [cht_pkg::BC_W-1:0]   bc_next;
    logic                       out_load;
    cht_pkg::res_t              stats_res;
    cht_pkg::req_e_t            in_req;

    assign in_req  = cht_pkg::req_e_t'(s_req_type);
    assign rd_key  = rd_data_reg[EW-1:VW];
    assign rd_val  = rd_data_reg[VW-1:0];
    assign key_hit = (rd_key == key_reg);
    assign val_hit = (rd_val == val_reg);

    assign trial    = {rem_reg, div_sh_reg[KW-1]};
    assign rem_next = (trial >= {1'b0, bc_reg}) ?
                      cht_pkg::BC_W'(trial - {1'b0, bc_reg}) : trial[cht_pkg::BC_W-1:0];

    assign is_remove = (req_reg == cht_pkg::REQ_REMOVE_KEY) ||
                       (req_reg == cht_pkg::REQ_REMOVE_VAL);

    always_comb begin
        keep = 1'b1;
        if (req_reg == cht_pkg::REQ_REMOVE_KEY) begin
            keep = !(key_hit && !dropped_reg);
        end else if (req_reg == cht_pkg::REQ_REMOVE_VAL) begin
            keep = !val_hit;
        end
    end

    // slot memory write port
    always_comb begin
        we    = 1'b0;
        waddr = {b_reg, w_reg[SW-1:0]};
        wdata = rd_data_reg;
        if (cmd.chk && is_remove && keep && (w_reg != r_reg)) begin
            we = 1'b1;
        end else if (cmd.bend && (req_reg == cht_pkg::REQ_INSERT) &&
                     (int'(fill_reg) < SLOTS_PER_BUCKET)) begin
            we    = 1'b1;
            waddr = {b_reg, fill_reg[SW-1:0]};
            wdata = {key_reg, val_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (cmd.rd) rd_data_reg <= mem[{b_reg, r_reg[SW-1:0]}];
    end

    always_comb begin
        if (cfg_wdata == '0) begin
            bc_next = cht_pkg::BC_W'(1);
        end else if (int'(cfg_wdata) > BUCKETS) begin
            bc_next = cht_pkg::BC_W'(BUCKETS);
        end else begin
            bc_next = cfg_wdata;
        end
    end

    always_comb begin
        stats_res          = cht_pkg::make_res(cht_pkg::ST_STATS, '0, '0, 1'b1);
        stats_res.total    = 7'(total_reg);
        stats_res.nonempty = 5'(nonempty_reg);
        stats_res.coll     = coll_reg;
    end

    assign out_load = cmd.emit || cmd.push;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUCKETS; i++) fill_arr_reg[i] <= '0;
            coll_reg       <= '0;
            total_reg      <= '0;
            nonempty_reg   <= '0;
            bc_reg         <= cht_pkg::BC_W'(RBC);
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            dropped_reg    <= 1'b0;
        end else begin
            if (cfg_we && (total_reg == '0)) bc_reg <= bc_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cmd.accept) begin
                pend_valid_reg <= 1'b0;
                dropped_reg    <= 1'b0;
            end
            if (cmd.load_bucket) dropped_reg <= 1'b0;

            if (cmd.chk) begin
                unique case (req_reg)
                    cht_pkg::REQ_INSERT: begin
                        if (!key_hit && (coll_reg != '1)) coll_reg <= coll_reg + 32'd1;
                    end
                    cht_pkg::REQ_FIND_VAL: begin
                        if (val_hit) pend_valid_reg <= 1'b1;
                    end
                    cht_pkg::REQ_REMOVE_KEY,
                    cht_pkg::REQ_REMOVE_VAL: begin
                        if (!keep) dropped_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (cmd.bend) begin
                unique case (req_reg)
                    cht_pkg::REQ_INSERT: begin
                        if (int'(fill_reg) < SLOTS_PER_BUCKET) begin
                            fill_arr_reg[b_reg] <= fill_reg + FW'(1);
                            total_reg           <= total_reg + TW'(1);
                            if (fill_reg == '0) nonempty_reg <= nonempty_reg + NEW'(1);
                        end
                    end
                    cht_pkg::REQ_REMOVE_KEY,
                    cht_pkg::REQ_REMOVE_VAL: begin
                        fill_arr_reg[b_reg] <= w_reg;
                        total_reg           <= total_reg - TW'(fill_reg - w_reg);
                        if ((fill_reg != '0) && (w_reg == '0)) begin
                            nonempty_reg <= nonempty_reg - NEW'(1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg    <= in_req;
            key_reg    <= s_key;
            val_reg    <= s_data_value;
            div_sh_reg <= s_key;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            b_reg      <= '0;
            res_reg    <= stats_res;
        end

        if (cmd.div_step) begin
            div_sh_reg <= {div_sh_reg[KW-2:0], 1'b0};
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_reg + 5'd1;
            if (sts.div_done) b_reg <= BW'(rem_next);
        end

        if (cmd.load_bucket) begin
            fill_reg <= fill_arr_reg[b_reg];
            r_reg    <= '0;
            w_reg    <= '0;
        end

        if (cmd.chk) begin
            unique case (req_reg)
                cht_pkg::REQ_INSERT: begin
                    if (key_hit) begin
                        res_reg <= cht_pkg::make_res(cht_pkg::ST_DUPLICATE, '0, '0, 1'b1);
                    end else begin
                        r_reg <= r_reg + FW'(1);
                    end
                end
                cht_pkg::REQ_FIND_KEY: begin
                    if (key_hit) begin
                        res_reg <= cht_pkg::make_res(cht_pkg::ST_FOUND, key_reg, rd_val, 1'b1);
                    end else begin
                        r_reg <= r_reg + FW'(1);
                    end
                end
                cht_pkg::REQ_FIND_VAL: begin
                    if (!(val_hit && pend_valid_reg)) r_reg <= r_reg + FW'(1);
                    if (val_hit && !pend_valid_reg) pend_key_reg <= rd_key;
                end
                cht_pkg::REQ_REMOVE_KEY,
                cht_pkg::REQ_REMOVE_VAL: begin
                    r_reg <= r_reg + FW'(1);
                    if (keep) w_reg <= w_reg + FW'(1);
                end
                default: ;
            endcase
        end

        if (cmd.push) begin
            pend_key_reg <= rd_key;
            r_reg        <= r_reg + FW'(1);
        end

        if (cmd.bend) begin
            if (sts.more_buckets) b_reg <= b_reg + BW'(1);
            unique case (req_reg)
                cht_pkg::REQ_INSERT: begin
                    res_reg <= cht_pkg::make_res((int'(fill_reg) < SLOTS_PER_BUCKET) ?
                               cht_pkg::ST_INSERTED : cht_pkg::ST_FULL, '0, '0, 1'b1);
                end
                cht_pkg::REQ_FIND_KEY: begin
                    res_reg <= cht_pkg::make_res(cht_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                end
                cht_pkg::REQ_FIND_VAL: begin
                    res_reg <= pend_valid_reg ?
                        cht_pkg::make_res(cht_pkg::ST_MATCH, pend_key_reg, val_reg, 1'b1) :
                        cht_pkg::make_res(cht_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                end
                cht_pkg::REQ_REMOVE_KEY: begin
                    res_reg <= cht_pkg::make_res(dropped_reg ? cht_pkg::ST_REMOVED :
                               cht_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                end
                cht_pkg::REQ_REMOVE_VAL: begin
                    res_reg <= cht_pkg::make_res(cht_pkg::ST_VAL_DONE, '0, '0, 1'b1);
                end
                default: ;
            endcase
        end

        if (cmd.emit) begin
            out_reg <= res_reg;
        end else if (cmd.push) begin
            out_reg <= cht_pkg::make_res(cht_pkg::ST_MATCH, pend_key_reg, val_reg, 1'b0);
        end
    end

    always_comb begin
        sts              = '0;
        sts.in_invalid   = (s_req_type > cht_pkg::REQ_STATS);
        sts.in_stats     = (in_req == cht_pkg::REQ_STATS);
        sts.in_keyed     = (in_req == cht_pkg::REQ_INSERT) ||
                           (in_req == cht_pkg::REQ_FIND_KEY) ||
                           (in_req == cht_pkg::REQ_REMOVE_KEY);
        sts.div_done     = (cnt_reg == 5'(KW - 1));
        sts.fill_zero    = (fill_arr_reg[b_reg] == '0);
        sts.hit_end      = key_hit && ((req_reg == cht_pkg::REQ_INSERT) ||
                                       (req_reg == cht_pkg::REQ_FIND_KEY));
        sts.push_need    = (req_reg == cht_pkg::REQ_FIND_VAL) && val_hit && pend_valid_reg;
        sts.last_slot    = ((r_reg + FW'(1)) == fill_reg);
        sts.more_buckets = ((req_reg == cht_pkg::REQ_FIND_VAL) ||
                            (req_reg == cht_pkg::REQ_REMOVE_VAL)) &&
                           ((NW'(b_reg) + NW'(1)) < NW'(bc_reg));
        sts.out_free     = !m_valid_reg || m_ready;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = out_reg.status;
    assign m_out_key          = out_reg.key;
    assign m_out_value        = out_reg.value;
    assign m_is_last          = out_reg.last;
    assign m_total_entries    = out_reg.total;
    assign m_nonempty_buckets = out_reg.nonempty;
    assign m_collision_total  = out_reg.coll;

endmodule

[design/chained_hash_table_core.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_core
// Key-value table with modulo hashing and bounded ordered chains per bucket.
// ----------------------------------------------------------------------------
// usage
//   s_ channel takes one request (type, key, value) when s_valid and s_ready
//   are high; s_ready is high only while no request is in progress
//   m_ channel returns results; find-by-value returns one per match, every
//   other known request type exactly one, is_last marks the final one
//   cfg_we writes bucket_count, taken only while the table is empty
// sequence
//   key requests: a bit-serial modulo of the key by bucket_count, then a read
//   and a check per slot scanned in the bucket (one slot memory read port)
//   value requests: the same scan over each bucket in use, one more push
//   per extra match; statistics straight to the result; unknown types dropped
// reset
//   aresetn empties every bucket, clears the collision counter and sets
//   bucket_count to 10; no clearing pass is needed
// stall
//   a held result keeps m_valid high; the next request may be accepted
//   meanwhile, its own result waits until the output register frees
// ----------------------------------------------------------------------------
module chained_hash_table_core #(
    parameter int BUCKETS          = cht_pkg::BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = cht_pkg::SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_req_type,
    input  logic [cht_pkg::KEY_W-1:0]   s_key,
    input  logic [cht_pkg::VAL_W-1:0]   s_data_value,
    input  logic                        cfg_we,
    input  logic [cht_pkg::BC_W-1:0]    cfg_wdata,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [3:0]                  m_status,
    output logic [cht_pkg::KEY_W-1:0]   m_out_key,
    output logic [cht_pkg::VAL_W-1:0]   m_out_value,
    output logic                        m_is_last,
    output logic [6:0]                  m_total_entries,
    output logic [4:0]                  m_nonempty_buckets,
    output logic [31:0]                 m_collision_total
);

    cht_pkg::cmd_t cmd;
    cht_pkg::sts_t sts;

    cht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cht_datapath #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_req_type         (s_req_type),
        .s_key              (s_key),
        .s_data_value       (s_data_value),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_out_key          (m_out_key),
        .m_out_value        (m_out_value),
        .m_is_last          (m_is_last),
        .m_total_entries    (m_total_entries),
        .m_nonempty_buckets (m_nonempty_buckets),
        .m_collision_total  (m_collision_total)
    );

endmodule

[design/cht_checker.sv]
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks on the result channel of the chained hash table core.
// ----------------------------------------------------------------------------
module cht_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [3:0]                  m_status,
    input logic [cht_pkg::KEY_W-1:0]   m_out_key,
    input logic [cht_pkg::VAL_W-1:0]   m_out_value,
    input logic                        m_is_last,
    input logic [6:0]                  m_total_entries,
    input logic [4:0]                  m_nonempty_buckets,
    input logic [31:0]                 m_collision_total
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_key)
                                && $stable(m_out_value) && $stable(m_is_last))
        else $error("result changed while stalled");

    // only matches of a value search can be followed by more results
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != cht_pkg::ST_MATCH) |-> m_is_last)
        else $error("single result without is_last");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= cht_pkg::ST_STATS))
        else $error("status code out of range");

    a_stats_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != cht_pkg::ST_STATS) |->
            (m_total_entries == '0) && (m_nonempty_buckets == '0) &&
            (m_collision_total == '0))
        else $error("statistics fields set on a non-statistics result");

    // a stats result shows no more nonempty buckets than entries
    a_stats_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == cht_pkg::ST_STATS) |->
            ({2'b00, m_nonempty_buckets} <= m_total_entries))
        else $error("more nonempty buckets than entries");

endmodule

bind chained_hash_table_core cht_checker u_cht_checker (.*);

[test/chained_hash_table_core_tb.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_core_tb
// Sends insert, find, remove and statistics requests through the valid/ready
// channel, predicts each result from a local copy of the table or a directed status, checks
// each returned result field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module chained_hash_table_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = cht_pkg::BUCKETS_DEF;
    localparam int NS = cht_pkg::SLOTS_DEF;
    localparam int KW = cht_pkg::KEY_W;
    localparam int VW = cht_pkg::VAL_W;

    typedef struct {
        logic [2:0]          req;
        logic [KW-1:0]       key;
        logic [VW-1:0]       value;
        bit                  typed;
        cht_pkg::status_e_t  status;
    } row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [2:0]                s_req_type;
    logic [KW-1:0]             s_key;
    logic [VW-1:0]             s_data_value;
    logic                      cfg_we;
    logic [cht_pkg::BC_W-1:0]  cfg_wdata;
    logic                      m_valid;
    logic                      m_ready;
    logic [3:0]                m_status;
    logic [KW-1:0]             m_out_key;
    logic [VW-1:0]             m_out_value;
    logic                      m_is_last;
    logic [6:0]                m_total_entries;
    logic [4:0]                m_nonempty_buckets;
    logic [31:0]               m_collision_total;

    // local copy of the table
    logic [KW-1:0]     tbl_key [NB][NS];
    logic [VW-1:0]     tbl_val [NB][NS];
    int                tbl_fill [NB];
    logic [31:0]       tbl_coll;
    int                tbl_buckets;

    cht_pkg::res_t     step_res [$];
    cht_pkg::res_t     pending_res [$];
    int                errors;
    int                send_idle;
    int                recv_idle;
    row_t              directed [$];

    chained_hash_table_core u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_key              (s_key),
        .s_data_value       (s_data_value),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_out_key          (m_out_key),
        .m_out_value        (m_out_value),
        .m_is_last          (m_is_last),
        .m_total_entries    (m_total_entries),
        .m_nonempty_buckets (m_nonempty_buckets),
        .m_collision_total  (m_collision_total)
    );

    always #2 aclk = ~aclk;

    function automatic int entry_count();
        int t;
        t = 0;
        for (int b = 0; b < NB; b++) t += tbl_fill[b];
        return t;
    endfunction

    function automatic void add_res(cht_pkg::res_t r);
        step_res.insert(step_res.size(), r);
    endfunction

    function automatic void drop_entry(int b, int s);
        for (int j = s; j + 1 < tbl_fill[b]; j++) begin
            tbl_key[b][j] = tbl_key[b][j+1];
            tbl_val[b][j] = tbl_val[b][j+1];
        end
        tbl_fill[b]--;
    endfunction

    function automatic void table_step(logic [2:0] req, logic [KW-1:0] key,
                                       logic [VW-1:0] value);
        int            b;
        int            s;
        int            ne;
        cht_pkg::res_t r;
        step_res.delete();
        b = int'(key % tbl_buckets);
        case (req)
            cht_pkg::REQ_INSERT: begin
                for (s = 0; s < tbl_fill[b]; s++) begin
                    if (tbl_key[b][s] == key) begin
                        add_res(cht_pkg::make_res(cht_pkg::ST_DUPLICATE, '0, '0, 1'b1));
                        return;
                    end
                    if (tbl_coll != 32'hFFFF_FFFF) tbl_coll++;
                end
                if (tbl_fill[b] >= NS) begin
                    add_res(cht_pkg::make_res(cht_pkg::ST_FULL, '0, '0, 1'b1));
                    return;
                end
                tbl_key[b][tbl_fill[b]] = key;
                tbl_val[b][tbl_fill[b]] = value;
                tbl_fill[b]++;
                add_res(cht_pkg::make_res(cht_pkg::ST_INSERTED, '0, '0, 1'b1));
            end
            cht_pkg::REQ_FIND_KEY: begin
                for (s = 0; s < tbl_fill[b]; s++) begin
                    if (tbl_key[b][s] == key) begin
                        add_res(cht_pkg::make_res(cht_pkg::ST_FOUND, key, tbl_val[b][s],
                                                  1'b1));
                        return;
                    end
                end
                add_res(cht_pkg::make_res(cht_pkg::ST_NOT_FOUND, '0, '0, 1'b1));
            end
            cht_pkg::REQ_FIND_VAL: begin
                for (b = 0; b < tbl_buckets; b++)
                    for (s = 0; s < tbl_fill[b]; s++)
                        if (tbl_val[b][s] == value)
                            add_res(cht_pkg::make_res(cht_pkg::ST_MATCH, tbl_key[b][s],
                                                      value, 1'b0));
                if (step_res.size() == 0)
                    add_res(cht_pkg::make_res(cht_pkg::ST_NOT_FOUND, '0, '0, 1'b1));
                else
                    step_res[step_res.size()-1].last = 1'b1;
            end
            cht_pkg::REQ_REMOVE_KEY: begin
                for (s = 0; s < tbl_fill[b]; s++) begin
                    if (tbl_key[b][s] == key) begin
                        drop_entry(b, s);
                        add_res(cht_pkg::make_res(cht_pkg::ST_REMOVED, '0, '0, 1'b1));
                        return;
                    end
                end
                add_res(cht_pkg::make_res(cht_pkg::ST_NOT_FOUND, '0, '0, 1'b1));
            end
            cht_pkg::REQ_REMOVE_VAL: begin
                for (b = 0; b < tbl_buckets; b++) begin
                    s = 0;
                    while (s < tbl_fill[b]) begin
                        if (tbl_val[b][s] == value) drop_entry(b, s);
                        else s++;
                    end
                end
                add_res(cht_pkg::make_res(cht_pkg::ST_VAL_DONE, '0, '0, 1'b1));
            end
            cht_pkg::REQ_STATS: begin
                ne = 0;
                for (b = 0; b < NB; b++) if (tbl_fill[b] != 0) ne++;
                r = cht_pkg::make_res(cht_pkg::ST_STATS, '0, '0, 1'b1);
                r.total    = 7'(entry_count());
                r.nonempty = 5'(ne);
                r.coll     = tbl_coll;
                add_res(r);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    // result side: random backpressure and checking
    always @(posedge aclk) begin
        cht_pkg::res_t e;
        if (aresetn === 1'b1) begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
            if (m_valid && m_ready) begin
                if (pending_res.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, status %0d", m_status));
                end else begin
                    e = pending_res.pop_front();
                    if (m_status !== 4'(e.status))
                        report_mismatch($sformatf("status %0d, want %0d", m_status, e.status));
                    if (m_out_key !== e.key)
                        report_mismatch($sformatf("key %0h, want %0h", m_out_key, e.key));
                    if (m_out_value !== e.value)
                        report_mismatch($sformatf("value %0h, want %0h", m_out_value, e.value));
                    if (m_is_last !== e.last)
                        report_mismatch($sformatf("is_last %0b, want %0b", m_is_last, e.last));
                    if (m_total_entries !== e.total)
                        report_mismatch($sformatf("total %0d, want %0d",
                                                  m_total_entries, e.total));
                    if (m_nonempty_buckets !== e.nonempty)
                        report_mismatch($sformatf("nonempty %0d, want %0d",
                                                  m_nonempty_buckets, e.nonempty));
                    if (m_collision_total !== e.coll)
                        report_mismatch($sformatf("collisions %0d, want %0d",
                                                  m_collision_total, e.coll));
                end
            end
        end
    end

    task automatic send_request(logic [2:0] req, logic [KW-1:0] key,
                                logic [VW-1:0] value, bit typed = 0,
                                cht_pkg::status_e_t status = cht_pkg::ST_INSERTED);
        cht_pkg::res_t r;
        @(posedge aclk);
        while ($urandom_range(0, 99) < send_idle) @(posedge aclk);
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_key        <= key;
        s_data_value <= value;
        table_step(req, key, value);
        if (typed) begin
            r = cht_pkg::make_res(status, '0, '0, 1'b1);
            step_res.delete();
            add_res(r);
        end
        foreach (step_res[i]) pending_res.insert(pending_res.size(), step_res[i]);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic write_buckets(logic [cht_pkg::BC_W-1:0] v);
        int n;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (entry_count() == 0) begin
            n = (v == 0) ? 1 : int'(v);
            tbl_buckets = (n > NB) ? NB : n;
        end
    endtask

    task automatic empty_table();
        for (int b = 0; b < NB; b++)
            while (tbl_fill[b] != 0)
                send_request(cht_pkg::REQ_REMOVE_KEY, tbl_key[b][0], {$urandom, $urandom});
    endtask

    task automatic random_requests(int count);
        int            c;
        logic [2:0]    req;
        logic [KW-1:0] key;
        logic [VW-1:0] value;
        for (int i = 0; i < count; i++) begin
            c = $urandom_range(0, 99);
            if (c < 40)      req = cht_pkg::REQ_INSERT;
            else if (c < 52) req = cht_pkg::REQ_FIND_KEY;
            else if (c < 62) req = cht_pkg::REQ_FIND_VAL;
            else if (c < 75) req = cht_pkg::REQ_REMOVE_KEY;
            else if (c < 80) req = cht_pkg::REQ_REMOVE_VAL;
            else if (c < 92) req = cht_pkg::REQ_STATS;
            else             req = 3'($urandom_range(6, 7));
            c = $urandom_range(0, 9);
            if (c < 7)      key = KW'($urandom_range(0, 40));
            else if (c < 9) key = KW'($urandom);
            else            key = {KW{1'b1}} - KW'($urandom_range(0, 3));
            c = $urandom_range(0, 4);
            case (c)
                0: value = '0;
                1: value = 64'd1;
                2: value = '1;
                3: value = 64'h5A5A_0000_0000_A5A5;
                default: value = {$urandom, $urandom};
            endcase
            send_request(req, key, value);
        end
    endtask

    initial begin
        errors      = 0;
        send_idle   = 8;
        recv_idle   = 50;
        tbl_buckets = cht_pkg::RESET_BUCKET_COUNT;
        tbl_coll    = '0;
        foreach (tbl_fill[b]) tbl_fill[b] = 0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= '0;
        s_key        <= '0;
        s_data_value <= '0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        m_ready      <= 1'b0;

        directed = '{
            '{cht_pkg::REQ_STATS,      31'd0,  64'd0, 1, cht_pkg::ST_STATS},
            '{cht_pkg::REQ_FIND_KEY,   31'd5,  64'd0, 1, cht_pkg::ST_NOT_FOUND},
            '{cht_pkg::REQ_FIND_VAL,   31'd0,  64'd0, 1, cht_pkg::ST_NOT_FOUND},
            '{cht_pkg::REQ_REMOVE_KEY, 31'd5,  64'd0, 1, cht_pkg::ST_NOT_FOUND},
            '{cht_pkg::REQ_REMOVE_VAL, 31'd0,  64'd0, 1, cht_pkg::ST_VAL_DONE},
            '{cht_pkg::REQ_INSERT,     31'd0,  64'd0, 1, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_INSERT,     31'd0,  64'd1, 1, cht_pkg::ST_DUPLICATE},
            '{cht_pkg::REQ_INSERT,     31'd16, '1,    0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_INSERT,     31'd32, 64'd0, 0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_INSERT,     31'd48, 64'd5, 0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_INSERT,     31'd64, 64'd6, 1, cht_pkg::ST_FULL},
            '{cht_pkg::REQ_INSERT,     '1,     64'd0, 0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_FIND_KEY,   '1,     64'd0, 0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_FIND_VAL,   31'd3,  64'd0, 0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_FIND_VAL,   31'd0,  '1,    0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_REMOVE_KEY, 31'd16, 64'd0, 0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_FIND_KEY,   31'd48, 64'd0, 0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_REMOVE_VAL, 31'd0,  64'd0, 0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_STATS,      31'd0,  64'd0, 0, cht_pkg::ST_INSERTED},
            '{3'd6,                    31'd1,  64'd1, 0, cht_pkg::ST_INSERTED},
            '{3'd7,                    '1,     '1,    0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_INSERT,   31'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0,
              cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_FIND_KEY, 31'h5555_5555, 64'd0, 0, cht_pkg::ST_INSERTED},
            '{cht_pkg::REQ_STATS,      31'd0,  64'd0, 0, cht_pkg::ST_INSERTED}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        write_buckets(5'd31);
        foreach (directed[i])
            send_request(directed[i].req, directed[i].key, directed[i].value,
                         directed[i].typed, directed[i].status);
        random_requests(45);
        write_buckets(5'd3);
        empty_table();

        send_idle = 50;
        recv_idle = 8;
        write_buckets(5'd0);
        random_requests(40);
        empty_table();

        send_idle = 0;
        recv_idle = 0;
        write_buckets(5'd16);
        random_requests(40);

        while (pending_res.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("chained_hash_table_core test passed");
        end else begin
            $display("chained_hash_table_core test failed");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("chained_hash_table_core test failed");
        $finish;
    end

endmodule

[filelist.f]
design/cht_pkg.sv
design/cht_ctrl.sv
design/cht_datapath.sv
design/chained_hash_table_core.sv
design/cht_checker.sv
test/chained_hash_table_core_tb.sv
